@@ hw/rtl/fpba_pkg.sv @@
// Shared constants, codes and controller/datapath bundles for the fit-policy allocator.
// Used by fpba_ctrl, fpba_dpath and fit_policy_block_allocator; no dependencies.
`default_nettype none

package fpba_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_BITS   = IDX_BITS + 1;

    // Fixed field widths
    localparam int KIND_BITS   = 1;
    localparam int BLK_BITS    = 4;
    localparam int AMT_BITS    = 16;
    localparam int POLICY_BITS = 2;
    localparam int COUNT_BITS  = 5;

    // Compare width covers both the stored size and the requested amount
    localparam int CMP_BITS = (SIZE_BITS > AMT_BITS) ? SIZE_BITS : AMT_BITS;
    localparam logic [CMP_BITS-1:0] SIZE_MAX =
        CMP_BITS'((64'd1 << SIZE_BITS) - 64'd1);

    // APB register map
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;
    localparam logic REG_FIT_POLICY    = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;
    localparam logic [POLICY_BITS-1:0] FIT_POLICY_RST    = 2'd0;
    localparam logic [COUNT_BITS-1:0]  BLOCKS_IN_USE_RST = 5'd16;

    // Item kinds
    localparam logic [KIND_BITS-1:0] KIND_LOAD    = 1'b0;
    localparam logic [KIND_BITS-1:0] KIND_REQUEST = 1'b1;

    // Policy codes; any other code behaves as first fit
    localparam logic [POLICY_BITS-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_BITS-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_BITS-1:0] POL_WORST = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // capture the incoming request
        logic load_wr;     // write a block's free size
        logic issue;       // read the next table entry
        logic write_back;  // store the reduced size of the chosen block
        logic post;        // load the result register
    } fpba_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;   // entry being issued is the last one scanned
        logic lim_zero;    // no block is scanned
        logic out_free;    // result register can take a new result
    } fpba_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/fpba_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fpba_ctrl.sv @@
// Sequencing controller for the allocator: accept, scan, drain, finish, hold.
// Depends on fpba_pkg.
`default_nettype none

module fpba_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [fpba_pkg::KIND_BITS-1:0] s_kind,
    input  wire fpba_pkg::fpba_sts_t           sts,
    output fpba_pkg::fpba_cmd_t                cmd
);
    import fpba_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Decode commands and next state
    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.accept     = accept;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_LOAD) begin
                        cmd.load_wr = 1'b1;
                    end else if (sts.lim_zero) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.write_back = 1'b1;
                if (sts.out_free) begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (sts.out_free) begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A result is only posted into a free result register
    a_post_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.post |-> sts.out_free)
        else $error("result posted while result register busy");

    // A load never produces a result on the following cycle
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_wr |=> !cmd.post)
        else $error("load produced a result");

    // Scanning never continues past the last entry
    a_scan_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue && sts.scan_last) |=> !cmd.issue)
        else $error("scan ran past its last entry");

endmodule

`default_nettype wire

@@ hw/rtl/fpba_dpath.sv @@
// Datapath for the allocator: free-space table, scan compare, best-pick registers, result register.
// Depends on fpba_pkg and fpba_ram.
`default_nettype none

module fpba_dpath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire fpba_pkg::fpba_cmd_t               cmd,
    output fpba_pkg::fpba_sts_t                    sts,
    input  wire logic [fpba_pkg::BLK_BITS-1:0]     s_block_number,
    input  wire logic [fpba_pkg::AMT_BITS-1:0]     s_amount,
    input  wire logic [fpba_pkg::POLICY_BITS-1:0]  fit_policy,
    input  wire logic [fpba_pkg::COUNT_BITS-1:0]   blocks_in_use,
    input  wire logic                              m_ready,
    output logic                                   m_valid,
    output logic                                   m_granted,
    output logic      [fpba_pkg::BLK_BITS-1:0]     m_chosen_block,
    output logic      [fpba_pkg::AMT_BITS-1:0]     m_space_left
);
    import fpba_pkg::*;

    // Request and scan state
    logic [AMT_BITS-1:0]   amt_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [IDX_BITS-1:0]   cmp_idx_reg;
    logic                  cmp_vld_reg;
    logic                  rd_vld_reg;
    logic                  found_reg;
    logic [IDX_BITS-1:0]   best_idx_reg;
    logic [SIZE_BITS-1:0]  best_val_reg;
    logic [NUM_BLOCKS-1:0] vld_reg;

    // Result register
    logic                  m_valid_reg;
    logic                  m_granted_reg;
    logic [BLK_BITS-1:0]   m_chosen_block_reg;
    logic [AMT_BITS-1:0]   m_space_left_reg;

    logic [CNT_BITS-1:0]   lim;
    logic                  ld_in_range;
    logic [CMP_BITS-1:0]   ld_amt;
    logic [SIZE_BITS-1:0]  ld_val;
    logic [SIZE_BITS-1:0]  rd_data;
    logic [SIZE_BITS-1:0]  have;
    logic                  fits;
    logic                  take;
    logic [CMP_BITS-1:0]   left_wide;
    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    logic [SIZE_BITS-1:0]  ram_wdata;

    // Clamp the scan count to the table depth
    assign lim = (32'(blocks_in_use) > NUM_BLOCKS) ? CNT_BITS'(NUM_BLOCKS)
                                                   : CNT_BITS'(blocks_in_use);

    assign sts.scan_last = ((CNT_BITS'(idx_reg) + CNT_BITS'(1)) == lim);
    assign sts.lim_zero  = (lim == '0);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Saturate and range-check a load
    assign ld_in_range = (32'(s_block_number) < NUM_BLOCKS);
    assign ld_amt      = CMP_BITS'(s_amount);
    assign ld_val      = (ld_amt > SIZE_MAX) ? SIZE_BITS'(SIZE_MAX) : SIZE_BITS'(ld_amt);

    // Entries never written read as zero
    assign have = rd_vld_reg ? rd_data : '0;
    assign fits = (CMP_BITS'(have) >= CMP_BITS'(amt_reg));

    // Policy pick; ties keep the lower index
    always_comb begin
        take = 1'b0;
        if (cmp_vld_reg && fits) begin
            if (!found_reg) begin
                take = 1'b1;
            end else if (fit_policy == POL_BEST) begin
                take = (have < best_val_reg);
            end else if (fit_policy == POL_WORST) begin
                take = (have > best_val_reg);
            end
        end
    end

    assign left_wide = CMP_BITS'(best_val_reg) - CMP_BITS'(amt_reg);

    // Table write: load or write-back of the chosen block
    assign ram_we    = (cmd.load_wr && ld_in_range) || (cmd.write_back && found_reg);
    assign ram_waddr = cmd.load_wr ? IDX_BITS'(s_block_number) : best_idx_reg;
    assign ram_wdata = cmd.load_wr ? ld_val : SIZE_BITS'(left_wide);

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // Valid bits: cleared at reset, set on first write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ram_we) begin
            vld_reg[ram_waddr] <= 1'b1;
        end
    end

    // Scan control: issue index, read pipeline, best pick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            cmp_vld_reg <= cmd.issue;
            if (cmd.accept) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end else begin
                if (cmd.issue) begin
                    idx_reg <= idx_reg + IDX_BITS'(1);
                end
                if (take) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers of the scan
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            amt_reg <= s_amount;
        end
        if (cmd.issue) begin
            cmp_idx_reg <= idx_reg;
            rd_vld_reg  <= vld_reg[idx_reg];
        end
        if (take) begin
            best_idx_reg <= cmp_idx_reg;
            best_val_reg <= have;
        end
    end

    // Result register: post, or drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.post) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.post) begin
            m_granted_reg      <= found_reg;
            m_chosen_block_reg <= found_reg ? BLK_BITS'(best_idx_reg) : '0;
            m_space_left_reg   <= found_reg ? AMT_BITS'(left_wide) : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_granted      = m_granted_reg;
    assign m_chosen_block = m_chosen_block_reg;
    assign m_space_left   = m_space_left_reg;

    // The held pick always covers the request
    a_best_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (found_reg && !cmd.accept && !$past(cmd.accept)) |->
            (CMP_BITS'(best_val_reg) >= CMP_BITS'(amt_reg)))
        else $error("chosen block smaller than request");

    // Reads stay inside the scanned range
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (CNT_BITS'(idx_reg) < lim))
        else $error("scan index beyond scan count");

    // A refused request reports zero block and zero space
    a_refuse_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.post) && !m_granted_reg |->
            (m_chosen_block_reg == '0) && (m_space_left_reg == '0))
        else $error("refusal with non-zero payload");

endmodule

`default_nettype wire

@@ hw/rtl/fit_policy_block_allocator.sv @@
// Top level of the fit-policy block allocator: APB register file, controller and datapath.
// Depends on fpba_pkg, fpba_ctrl, fpba_dpath (and through it fpba_ram).
//
//  port group | direction | carries
//  -----------+-----------+-----------------------------------------------
//  s_*        | in        | load or allocation request (kind, block, amount)
//  m_*        | out       | allocation result (granted, block, space left)
//  APB        | in/out    | fit_policy at 0x0, blocks_in_use at 0x4
//
// A load is written into the table at acceptance.
// A request scans the first N blocks, N being the scan count, and the block takes no
// new request until that request's result is posted.
// A request with a scan count of zero skips the scan and presents a refusal.
// Reset clears the table (through per-entry valid bits) and the result valid flag and
// resets fit_policy to first fit and blocks_in_use to 16. A stalled result holds the
// block until it is taken; the next request is accepted once the block returns to idle.
`default_nettype none

module fit_policy_block_allocator (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Request channel
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [fpba_pkg::KIND_BITS-1:0]   s_kind,
    input  wire logic [fpba_pkg::BLK_BITS-1:0]    s_block_number,
    input  wire logic [fpba_pkg::AMT_BITS-1:0]    s_amount,
    // Result channel
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_granted,
    output logic      [fpba_pkg::BLK_BITS-1:0]    m_chosen_block,
    output logic      [fpba_pkg::AMT_BITS-1:0]    m_space_left,
    // Configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [fpba_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [fpba_pkg::DATA_BITS-1:0]   pwdata,
    output logic      [fpba_pkg::DATA_BITS-1:0]   prdata,
    output logic                                  pready
);
    import fpba_pkg::*;

    logic [POLICY_BITS-1:0] fit_policy_reg;
    logic [COUNT_BITS-1:0]  blocks_in_use_reg;
    logic                   reg_sel;
    logic                   cfg_wr;
    fpba_cmd_t              cmd;
    fpba_sts_t              sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_policy_reg    <= FIT_POLICY_RST;
            blocks_in_use_reg <= BLOCKS_IN_USE_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_FIT_POLICY:    fit_policy_reg    <= pwdata[POLICY_BITS-1:0];
                REG_BLOCKS_IN_USE: blocks_in_use_reg <= pwdata[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_sel)
            REG_FIT_POLICY:    prdata = DATA_BITS'(fit_policy_reg);
            REG_BLOCKS_IN_USE: prdata = DATA_BITS'(blocks_in_use_reg);
            default:           prdata = '0;
        endcase
    end

    fpba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    fpba_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_block_number (s_block_number),
        .s_amount       (s_amount),
        .fit_policy     (fit_policy_reg),
        .blocks_in_use  (blocks_in_use_reg),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_granted      (m_granted),
        .m_chosen_block (m_chosen_block),
        .m_space_left   (m_space_left)
    );

endmodule

`default_nettype wire

@@ test/tb_fit_policy_block_allocator.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for fit_policy_block_allocator: directed and random load and
// allocation traffic under APB policy changes, checked against an in-bench allocator model.
// Depends on fpba_pkg and the allocator RTL; needs no files or arguments.

module tb_fit_policy_block_allocator;
    import fpba_pkg::*;

    // Spare policy code, expected to behave as first fit
    localparam logic [POLICY_BITS-1:0] POL_SPARE = 2'd3;
    localparam logic [ADDR_BITS-1:0] ADDR_FIT_POLICY    = {REG_FIT_POLICY, 2'b00};
    localparam logic [ADDR_BITS-1:0] ADDR_BLOCKS_IN_USE = {REG_BLOCKS_IN_USE, 2'b00};
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_GUARD   = 4000;
    localparam int RANDOM_ROUNDS = 15;
    localparam int ROUND_ITEMS   = 102;
    localparam int QUIET_ROUNDS  = 3;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic                granted;
        logic [BLK_BITS-1:0] chosen_block;
        logic [AMT_BITS-1:0] space_left;
    } grant_t;

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [KIND_BITS-1:0]  s_kind         = KIND_LOAD;
    logic [BLK_BITS-1:0]   s_block_number = '0;
    logic [AMT_BITS-1:0]   s_amount       = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_granted;
    logic [BLK_BITS-1:0]   m_chosen_block;
    logic [AMT_BITS-1:0]   m_space_left;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [ADDR_BITS-1:0]  paddr          = '0;
    logic [DATA_BITS-1:0]  pwdata         = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    // Allocator model state and the grants still owed by the block
    logic [SIZE_BITS-1:0]   free_left [NUM_BLOCKS];
    logic [POLICY_BITS-1:0] cur_policy;
    logic [COUNT_BITS-1:0]  cur_scan;
    grant_t                 pending_grants [$];
    int                     bad_results = 0;
    bit                     idling = 1'b0;

    fit_policy_block_allocator DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_block_number (s_block_number),
        .s_amount       (s_amount),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_granted      (m_granted),
        .m_chosen_block (m_chosen_block),
        .m_space_left   (m_space_left),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Pick the block for an allocation request and take the amount out of it
    function automatic grant_t place_request(logic [AMT_BITS-1:0] want);
        int                  limit;
        logic [IDX_BITS-1:0] pick;
        logic [IDX_BITS-1:0] jx;
        bit                  found;
        bit                  stop;
        grant_t              res;
        limit = (cur_scan > NUM_BLOCKS) ? NUM_BLOCKS : int'(cur_scan);
        pick  = '0;
        found = 1'b0;
        stop  = 1'b0;
        for (int j = 0; j < limit && !stop; j++) begin
            jx = IDX_BITS'(j);
            if (free_left[jx] >= want) begin
                if (!found) begin
                    found = 1'b1;
                    pick  = jx;
                    // first fit, spare code included, settles on the first candidate
                    stop  = (cur_policy != POL_BEST) && (cur_policy != POL_WORST);
                end else if (cur_policy == POL_BEST && free_left[jx] < free_left[pick]) begin
                    pick = jx;
                end else if (cur_policy == POL_WORST && free_left[jx] > free_left[pick]) begin
                    pick = jx;
                end
            end
        end
        res = '0;
        if (found) begin
            free_left[pick]  = free_left[pick] - want;
            res.granted      = 1'b1;
            res.chosen_block = BLK_BITS'(pick);
            res.space_left   = AMT_BITS'(free_left[pick]);
        end
        return res;
    endfunction

    // Random idle burst length, zero when idling is off or not drawn
    function automatic int idle_burst();
        if (idling && $urandom_range(0, 5) == 0)
            return $urandom_range(1, 12);
        return 0;
    endfunction

    // Drive one request and update the model once the block takes it
    task automatic send_item(input logic [KIND_BITS-1:0] k, input logic [BLK_BITS-1:0] b,
                             input logic [AMT_BITS-1:0] a);
        int gap;
        gap = idle_burst();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= k;
        s_block_number <= b;
        s_amount       <= a;
        do @(posedge aclk); while (!s_ready);
        if (k == KIND_LOAD) begin
            if (b < NUM_BLOCKS)
                free_left[b] = (a > SIZE_MAX) ? SIZE_MAX[SIZE_BITS-1:0] : SIZE_BITS'(a);
        end else begin
            pending_grants.push_back(place_request(a));
        end
    endtask

    // Drop valid, wait for every owed grant, then let the block go quiet
    task automatic drain_results();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_grants.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup phase, then access phase until pready
    task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_FIT_POLICY)
            cur_policy = value[POLICY_BITS-1:0];
        else if (addr == ADDR_BLOCKS_IN_USE)
            cur_scan = value[COUNT_BITS-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [POLICY_BITS-1:0] policy,
                              input logic [COUNT_BITS-1:0] scan);
        drain_results();
        write_reg(ADDR_FIT_POLICY, DATA_BITS'(policy));
        write_reg(ADDR_BLOCKS_IN_USE, DATA_BITS'(scan));
    endtask

    task automatic log_mismatch(input string why, input grant_t want, input grant_t got);
        bad_results++;
        if (bad_results <= REPORT_LIMIT)
            $display("%0t: %s: expected g=%0d blk=%0d left=%0d, got g=%0d blk=%0d left=%0d",
                     $realtime, why, want.granted, want.chosen_block, want.space_left,
                     got.granted, got.chosen_block, got.space_left);
    endtask

    // Result sink: random back-pressure bursts on m_ready
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = idle_burst();
            end
        end
    end

    // Compare every taken result with the oldest owed grant
    always @(posedge aclk) begin : check_result
        grant_t got;
        grant_t want;
        if (aresetn && m_valid && m_ready) begin
            got.granted      = m_granted;
            got.chosen_block = m_chosen_block;
            got.space_left   = m_space_left;
            if (pending_grants.size() == 0) begin
                log_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_grants.pop_front();
                if (got.granted !== want.granted || got.chosen_block !== want.chosen_block ||
                    got.space_left !== want.space_left)
                    log_mismatch("result mismatch", want, got);
            end
        end
    end

    // Defaults after reset: empty table, zero request still fits block zero
    task automatic test_reset_defaults();
        send_item(KIND_REQUEST, 4'd0, 16'd0);
        send_item(KIND_REQUEST, 4'd15, 16'd1);
        send_item(KIND_REQUEST, 4'd7, 16'hFFFF);
    endtask

    // Each policy, ties, spare code and scan count extremes on a hand-made table
    task automatic test_policy_switching();
        send_item(KIND_LOAD, 4'd0, 16'd100);
        send_item(KIND_LOAD, 4'd1, 16'd50);
        send_item(KIND_LOAD, 4'd2, 16'd300);
        send_item(KIND_LOAD, 4'd3, 16'd50);
        send_item(KIND_LOAD, 4'd4, 16'd300);
        send_item(KIND_LOAD, 4'd15, 16'hFFFF);
        send_item(KIND_REQUEST, 4'd9, 16'd40);
        set_config(POL_BEST, 5'd16);
        send_item(KIND_REQUEST, 4'd0, 16'd45);
        send_item(KIND_REQUEST, 4'd0, 16'd0);
        set_config(POL_WORST, 5'd16);
        send_item(KIND_REQUEST, 4'd0, 16'd1000);
        send_item(KIND_REQUEST, 4'd0, 16'hFFFF);
        send_item(KIND_LOAD, 4'd2, 16'd0);
        set_config(POL_SPARE, 5'd16);
        send_item(KIND_REQUEST, 4'd0, 16'd10);
        set_config(POL_FIRST, 5'd0);
        send_item(KIND_REQUEST, 4'd0, 16'd0);
        set_config(POL_BEST, 5'd1);
        send_item(KIND_REQUEST, 4'd0, 16'd20);
        send_item(KIND_REQUEST, 4'd0, 16'd100);
        set_config(POL_WORST, 5'd31);
        send_item(KIND_REQUEST, 4'd0, 16'd1);
        set_config(POL_FIRST, 5'd16);
    endtask

    // Rounds of random settings: refill the table, then mostly allocation requests
    task automatic test_random_traffic();
        logic [POLICY_BITS-1:0] policy;
        logic [COUNT_BITS-1:0]  scan;
        logic [BLK_BITS-1:0]    blk;
        logic [AMT_BITS-1:0]    amt;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            policy = POLICY_BITS'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       scan = 5'd0;
                1:       scan = 5'd1;
                2:       scan = COUNT_BITS'($urandom_range(17, 31));
                3, 4:    scan = 5'd16;
                default: scan = COUNT_BITS'($urandom_range(2, 15));
            endcase
            set_config(policy, scan);
            idling = (round < RANDOM_ROUNDS - QUIET_ROUNDS) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < ROUND_ITEMS; i++) begin
                blk = BLK_BITS'($urandom_range(0, NUM_BLOCKS - 1));
                if (i < NUM_BLOCKS) begin
                    // refill every block, with some duplicate sizes for tie breaks
                    blk = BLK_BITS'(i);
                    if (i > 0 && $urandom_range(0, 3) == 0)
                        amt = free_left[IDX_BITS'($urandom_range(0, i - 1))];
                    else
                        amt = AMT_BITS'($urandom_range(0, 16'hFFFF));
                    send_item(KIND_LOAD, blk, amt);
                end else if ($urandom_range(0, 9) < 2) begin
                    amt = ($urandom_range(0, 1) == 0) ? AMT_BITS'($urandom_range(0, 16'hFFFF))
                                                      : AMT_BITS'($urandom_range(0, 4095));
                    send_item(KIND_LOAD, blk, amt);
                end else begin
                    case ($urandom_range(0, 9))
                        0:       amt = 16'd0;
                        1, 2:    amt = free_left[IDX_BITS'($urandom_range(0, NUM_BLOCKS - 1))];
                        3:       amt = AMT_BITS'($urandom_range(0, 16'hFFFF));
                        4, 5:    amt = AMT_BITS'($urandom_range(0, 4095));
                        default: amt = AMT_BITS'($urandom_range(0, 255));
                    endcase
                    send_item(KIND_REQUEST, blk, amt);
                end
            end
        end
    endtask

    initial begin : run_tests
        for (int j = 0; j < NUM_BLOCKS; j++)
            free_left[IDX_BITS'(j)] = '0;
        cur_policy = FIT_POLICY_RST;
        cur_scan   = BLOCKS_IN_USE_RST;
        // hold reset, then release it on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_policy_switching();
        test_random_traffic();
        idling = 1'b0;
        drain_results();
        if (bad_results == 0 && pending_grants.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
